FILE: rtl/tps_pkg.sv
// tps_pkg: shared types, opcodes, constants and built-in tone patterns
// for the tone pattern sequencer. No dependencies.

package tps_pkg;

   // default number of steps a pattern may hold
   localparam int DefaultMaxSteps = 8;

   // physical step store: load_index is three bits wide, so only eight entries
   // can ever be written
   localparam int StoreDepth = 8;
   localparam int StoreAddrW = 3;

   localparam int FreqW = 16;
   localparam int MsW   = 16;

   // duty value for a sounding tone (128 of 256, half duty)
   localparam logic [7:0] ToneDuty = 8'd128;

   // item opcodes
   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_PLAY  = 3'd2,
      OP_OK    = 3'd3,
      OP_ERROR = 3'd4,
      OP_CARD  = 3'd5,
      OP_STOP  = 3'd6
   } op_type;

   // built-in patterns
   typedef enum logic [1:0] {
      ROM_OK,
      ROM_ERROR,
      ROM_CARD
   } rom_sel_type;

   // one step: frequency and duration
   typedef struct packed {
      logic [FreqW-1:0] freq;
      logic [MsW-1:0]   ms;
   } step_type;

   // write command from the sequencer control to the step store
   typedef struct packed {
      logic                  load_en;
      logic [StoreAddrW-1:0] load_idx;
      step_type              load_step;
      logic                  rom_en;
      rom_sel_type           rom_sel;
   } store_cmd_type;

   // number of steps in a built-in pattern
   function automatic logic [2:0] rom_len(input rom_sel_type sel);
      logic [2:0] len;
      case (sel)
         ROM_OK:    len = 3'd3;
         ROM_ERROR: len = 3'd5;
         ROM_CARD:  len = 3'd3;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   // one entry of a built-in pattern
   function automatic step_type rom_entry(input rom_sel_type sel,
                                          input logic [StoreAddrW-1:0] idx);
      step_type s;
      s = '{freq: 16'd0, ms: 16'd0};
      case (sel)
         ROM_OK: begin
            case (idx)
               3'd0:    s = '{freq: 16'd2000, ms: 16'd80};
               3'd1:    s = '{freq: 16'd0,    ms: 16'd40};
               3'd2:    s = '{freq: 16'd2400, ms: 16'd80};
               default: s = '{freq: 16'd0,    ms: 16'd0};
            endcase
         end
         ROM_ERROR: begin
            case (idx)
               3'd0:    s = '{freq: 16'd800, ms: 16'd200};
               3'd1:    s = '{freq: 16'd0,   ms: 16'd80};
               3'd2:    s = '{freq: 16'd800, ms: 16'd200};
               3'd3:    s = '{freq: 16'd0,   ms: 16'd80};
               3'd4:    s = '{freq: 16'd800, ms: 16'd240};
               default: s = '{freq: 16'd0,   ms: 16'd0};
            endcase
         end
         ROM_CARD: begin
            case (idx)
               3'd0:    s = '{freq: 16'd1800, ms: 16'd60};
               3'd1:    s = '{freq: 16'd0,    ms: 16'd30};
               3'd2:    s = '{freq: 16'd1800, ms: 16'd60};
               default: s = '{freq: 16'd0,    ms: 16'd0};
            endcase
         end
         default: s = '{freq: 16'd0, ms: 16'd0};
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/tps_req_if.sv
// tps_req_if: request channel of the tone pattern sequencer
// (valid/ready handshake with opcode item payload). No dependencies.

interface tps_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  load_index;
   logic [15:0] load_freq;
   logic [15:0] load_ms;
   logic [3:0]  play_count;

   modport source (output valid, output opcode, output load_index, output load_freq,
                   output load_ms, output play_count, input ready);
   modport sink   (input valid, input opcode, input load_index, input load_freq,
                   input load_ms, input play_count, output ready);
endinterface

FILE: rtl/tps_rsp_if.sv
// tps_rsp_if: response channel of the tone pattern sequencer
// (valid/ready handshake with tone status payload). No dependencies.

interface tps_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tone_hz;
   logic        tone_on;
   logic        playing;
   logic [2:0]  step_position;

   modport source (output valid, output tone_hz, output tone_on, output playing,
                   output step_position, input ready);
   modport sink   (input valid, input tone_hz, input tone_on, input playing,
                   input step_position, output ready);
endinterface

FILE: rtl/tone_pattern_sequencer_top.sv
// tone_pattern_sequencer_top: tone step sequencer with opcode request channel
// and status response channel. Depends on tps_pkg, tps_req_if, tps_rsp_if
// and tps_step_store.
// Response: valid is registered in the cycle after the request transfer.
// Throughput: one item per cycle; the response register frees itself in the
// same cycle it is taken, so requests keep flowing while the sink is ready.
// Reset: synchronous, clears playback state and the response valid; the
// response payload and the step store are not cleared and hold undefined values until written.

module tone_pattern_sequencer_top #(
   parameter int MAX_STEPS = tps_pkg::DefaultMaxSteps
) (
   input  logic     clock,
   input  logic     reset,
   tps_req_if.sink   req_ch,
   tps_rsp_if.source rsp_ch
);
   import tps_pkg::*;

   localparam int StepW  = $clog2(MAX_STEPS);
   localparam int CountW = $clog2(MAX_STEPS + 1);

   // playback state
   logic [CountW-1:0] steps_ff,   steps_in;
   logic [StepW-1:0]  cur_ff,     cur_in;
   logic              active_ff,  active_in;
   logic [MsW-1:0]    elapsed_ff, elapsed_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FreqW-1:0]  tone_hz_ff,   tone_hz_in;
   logic              tone_on_ff,   tone_on_in;
   logic              playing_ff,   playing_in;
   logic [2:0]        pos_ff,       pos_in;

   logic              req_xfer;
   op_type            op;
   store_cmd_type     cmd;
   logic [MsW-1:0]    dur_rd;
   logic [FreqW-1:0]  freq_rd;
   logic [MsW-1:0]    elapsed_sat;
   logic [StepW:0]    step_inc;
   logic [7:0]        count_ext;

   // handshake: accept whenever the response register is empty or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.opcode);

   // store write command
   always_comb begin
      cmd.load_en   = req_xfer && (op == OP_LOAD);
      cmd.load_idx  = req_ch.load_index;
      cmd.load_step = '{freq: req_ch.load_freq, ms: req_ch.load_ms};
      cmd.rom_en    = req_xfer && ((op == OP_OK) || (op == OP_ERROR) || (op == OP_CARD));
      case (op)
         OP_OK:    cmd.rom_sel = ROM_OK;
         OP_ERROR: cmd.rom_sel = ROM_ERROR;
         OP_CARD:  cmd.rom_sel = ROM_CARD;
         default:  cmd.rom_sel = ROM_OK;
      endcase
   end

   tps_step_store #(
      .MAX_STEPS (MAX_STEPS)
   ) u_store (
      .clock     (clock),
      .cmd       (cmd),
      .dur_addr  (cur_ff[StoreAddrW-1:0]),
      .freq_addr (cur_in[StoreAddrW-1:0]),
      .dur_rd    (dur_rd),
      .freq_rd   (freq_rd)
   );

   // tick arithmetic
   assign elapsed_sat = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign step_inc    = {1'b0, cur_ff} + 1'b1;
   assign count_ext   = 8'(req_ch.play_count);

   // next playback state
   always_comb begin
      steps_in   = steps_ff;
      cur_in     = cur_ff;
      active_in  = active_ff;
      elapsed_in = elapsed_ff;
      if (req_xfer) begin
         case (op)
            OP_TICK: begin
               if (active_ff) begin
                  elapsed_in = elapsed_sat;
                  if (elapsed_sat >= dur_rd) begin
                     if (step_inc >= (StepW+1)'(steps_ff)) begin
                        active_in = 1'b0;
                        steps_in  = '0;
                        cur_in    = '0;
                     end else begin
                        cur_in     = step_inc[StepW-1:0];
                        elapsed_in = '0;
                     end
                  end
               end
            end
            OP_PLAY: begin
               if (count_ext != 8'd0) begin
                  steps_in   = (count_ext > 8'(MAX_STEPS)) ? CountW'(MAX_STEPS)
                                                           : CountW'(count_ext);
                  cur_in     = '0;
                  elapsed_in = '0;
                  active_in  = 1'b1;
               end
            end
            OP_OK, OP_ERROR, OP_CARD: begin
               steps_in   = CountW'(rom_len(cmd.rom_sel));
               cur_in     = '0;
               elapsed_in = '0;
               active_in  = 1'b1;
            end
            OP_STOP: begin
               active_in = 1'b0;
               steps_in  = '0;
               cur_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // response contents and valid
   always_comb begin
      tone_hz_in   = active_in ? freq_rd : '0;
      tone_on_in   = active_in && (freq_rd != '0);
      playing_in   = active_in;
      pos_in       = active_in ? cur_in[2:0] : 3'd0;
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff     <= '0;
         cur_ff       <= '0;
         active_ff    <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         steps_ff     <= steps_in;
         cur_ff       <= cur_in;
         active_ff    <= active_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tone_hz_ff <= tone_hz_in;
         tone_on_ff <= tone_on_in;
         playing_ff <= playing_in;
         pos_ff     <= pos_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.tone_hz       = tone_hz_ff;
   assign rsp_ch.tone_on       = tone_on_ff;
   assign rsp_ch.playing       = playing_ff;
   assign rsp_ch.step_position = pos_ff;

   // an active pattern always has steps and a step index inside it
   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (steps_ff != '0) && ((StepW+1)'(cur_ff) < (StepW+1)'(steps_ff)))
      else $error("active playback with step index outside the pattern");

   // idle state keeps the step index at zero
   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (cur_ff == '0) && (steps_ff == '0))
      else $error("idle sequencer holds a nonzero step index");

   // every request transfer yields a response in the next cycle
   a_xfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("request transfer without a response");

   // a sounding tone is reported only while playing and with a nonzero frequency
   a_tone_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && tone_on_ff) |-> (playing_ff && (tone_hz_ff != '0)))
      else $error("tone on without playback or with zero frequency");

   // stopped responses report silence at step zero
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !playing_ff) |-> ((tone_hz_ff == '0) && (pos_ff == 3'd0)))
      else $error("stopped response reports a tone or step");

endmodule

FILE: rtl/tps_step_store.sv
// tps_step_store: eight-entry frequency/duration store with load and
// built-in pattern writes; read ports see the contents after this cycle's write.
// Depends on tps_pkg.

module tps_step_store #(
   parameter int MAX_STEPS = tps_pkg::DefaultMaxSteps
) (
   input  logic                            clock,
   input  tps_pkg::store_cmd_type          cmd,
   input  logic [tps_pkg::StoreAddrW-1:0]  dur_addr,
   input  logic [tps_pkg::StoreAddrW-1:0]  freq_addr,
   output logic [tps_pkg::MsW-1:0]         dur_rd,
   output logic [tps_pkg::FreqW-1:0]       freq_rd
);
   import tps_pkg::*;

   step_type step_ff [StoreDepth];
   step_type step_in [StoreDepth];
   logic     load_ok;
   logic [2:0] pat_len;

   // loads to an index at or beyond MAX_STEPS are dropped
   assign load_ok = 8'(cmd.load_idx) < 8'(MAX_STEPS);
   assign pat_len = rom_len(cmd.rom_sel);

   // next contents: single load or built-in pattern copy
   always_comb begin
      for (int i = 0; i < StoreDepth; i++) begin
         step_in[i] = step_ff[i];
         if (cmd.rom_en && (3'(i) < pat_len)) begin
            step_in[i] = rom_entry(cmd.rom_sel, 3'(i));
         end else if (cmd.load_en && load_ok && (cmd.load_idx == 3'(i))) begin
            step_in[i] = cmd.load_step;
         end
      end
   end

   // storage, no reset: entries are undefined until written
   always_ff @(posedge clock) begin
      for (int i = 0; i < StoreDepth; i++) begin
         step_ff[i] <= step_in[i];
      end
   end

   // read ports
   assign dur_rd  = step_in[dur_addr].ms;
   assign freq_rd = step_in[freq_addr].freq;

endmodule
